>>> hdl/nsq_pkg.sv
// Nine-slice quad generator: shared constants and types.
// No dependencies; used by the vertex channel interface and the top level.
`default_nettype none

package nsq_pkg;

  // Fixed-point formats
  localparam int POS_FRAC_BITS = 4;
  localparam int UV_FRAC_BITS  = 15;
  localparam int POS_W         = 13 + POS_FRAC_BITS;  // Q13.4 positions
  localparam int UV_W          = 18;                  // Q2.15 texture values
  localparam int QCNT_W        = 4;
  localparam int CFG_W         = 32;
  localparam int CFG_IDX_W     = 3;

  // Register reset values
  localparam logic [CFG_W-1:0] SLICE_SIZE_RST = 32'h0400_0400;
  localparam logic [CFG_W-1:0] TEX_EXTENT_RST = 32'h8000_8000;
  localparam logic [CFG_W-1:0] COLOR_RST      = 32'hFFFF_FFFF;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLICE_SIZE   = 3'd0,
    REG_TL_SIZE      = 3'd1,
    REG_BR_SIZE      = 3'd2,
    REG_TL_FRAC      = 3'd3,
    REG_BR_FRAC      = 3'd4,
    REG_TEX_ORIGIN   = 3'd5,
    REG_TEX_EXTENT   = 3'd6,
    REG_VERTEX_COLOR = 3'd7
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SPAN,
    ST_WALK,
    ST_NONE
  } nsq_state_t;

endpackage

`default_nettype wire

>>> hdl/nsq_in_if.sv
// Request channel of the nine-slice quad generator.
// Carries one start word; no package dependency.
`default_nettype none

interface nsq_in_if;
  logic valid;
  logic ready;
  logic start_req;

  modport source (output valid, output start_req, input ready);
  modport sink   (input valid, input start_req, output ready);
endinterface

`default_nettype wire

>>> hdl/nsq_out_if.sv
// Vertex channel of the nine-slice quad generator.
// Depends on nsq_pkg for the field widths.
`default_nettype none

interface nsq_out_if import nsq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [POS_W-1:0]         pos_x;
  logic [POS_W-1:0]         pos_y;
  logic signed [UV_W-1:0]   tex_u;
  logic signed [UV_W-1:0]   tex_v;
  logic [CFG_W-1:0]         color;
  logic                     has_vertex;
  logic                     is_last;
  logic [QCNT_W-1:0]        quad_count;
  logic [POS_W-1:0]         box_max_x;
  logic [POS_W-1:0]         box_max_y;

  modport source (output valid, output pos_x, output pos_y, output tex_u, output tex_v,
                  output color, output has_vertex, output is_last, output quad_count,
                  output box_max_x, output box_max_y, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input tex_u, input tex_v,
                  input color, input has_vertex, input is_last, input quad_count,
                  input box_max_x, input box_max_y, output ready);
endinterface

`default_nettype wire

>>> hdl/nine_slice_quad_generator.sv
// Nine-slice quad generator top level: config registers, span setup and vertex walker.
// Depends on nsq_pkg, nsq_in_if and nsq_out_if.
//
//   channel   dir   handshake           payload
//   in_if     in    valid/ready         start_req
//   out_if    out   valid/ready         one vertex word (position, uv, color, flags, box)
//   cfg_*     in    cfg_we              cfg_index, cfg_wdata
//
// A start word is held in the input register, then passes the setup states ST_MUL (corner
// span products) and ST_SPAN (middle spans and last-cell search); then the walker emits each
// vertex and steps over each skipped row or column ahead of the last cell, a full 3x3 grid
// being the longest case. A word of 0 is taken and dropped.
// One further request is held in the input register while the walker runs.
// Output stalls hold the walker; reset (synchronous, rst_n low) restores config and control.
`default_nettype none

module nine_slice_quad_generator import nsq_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  nsq_in_if.sink                    in_if,
  nsq_out_if.source                 out_if,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int SW = 18;  // signed row/column sizes
  localparam int UW = 22;  // signed texture accumulators

  function automatic logic signed [UW-1:0] rnd_span(input logic [15:0] f,
                                                    input logic [15:0] e);
    logic [32:0] p;
    p = ({17'd0, f} * {17'd0, e}) + (33'd1 << (UV_FRAC_BITS - 1));
    return UW'(p >> UV_FRAC_BITS);
  endfunction

  function automatic logic signed [UV_W-1:0] sat_uv(input logic signed [UW-1:0] v);
    logic signed [UW-1:0] hi;
    logic signed [UW-1:0] lo;
    hi = UW'(131071);
    lo = -UW'(131072);
    if (v > hi) return hi[UV_W-1:0];
    else if (v < lo) return lo[UV_W-1:0];
    else return v[UV_W-1:0];
  endfunction

  // Configuration registers
  logic [CFG_W-1:0] slice_r, tlsz_r, brsz_r, tlfr_r, brfr_r, org_r, ext_r, color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_r <= SLICE_SIZE_RST;
      tlsz_r  <= '0;
      brsz_r  <= '0;
      tlfr_r  <= '0;
      brfr_r  <= '0;
      org_r   <= '0;
      ext_r   <= TEX_EXTENT_RST;
      color_r <= COLOR_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SLICE_SIZE:   slice_r <= cfg_wdata;
        REG_TL_SIZE:      tlsz_r  <= cfg_wdata;
        REG_BR_SIZE:      brsz_r  <= cfg_wdata;
        REG_TL_FRAC:      tlfr_r  <= cfg_wdata;
        REG_BR_FRAC:      brfr_r  <= cfg_wdata;
        REG_TEX_ORIGIN:   org_r   <= cfg_wdata;
        REG_TEX_EXTENT:   ext_r   <= cfg_wdata;
        REG_VERTEX_COLOR: color_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register: one pending start request
  logic req_pend_r;
  logic in_take;
  nsq_state_t state_r, state_nxt;

  assign in_if.ready = !req_pend_r;
  assign in_take     = in_if.valid && in_if.ready && in_if.start_req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_pend_r <= 1'b0;
    end else if (in_take) begin
      req_pend_r <= 1'b1;
    end else if (state_r == ST_IDLE) begin
      req_pend_r <= 1'b0;
    end
  end

  // Geometry registers
  logic signed [SW-1:0] hgt_r [3];
  logic signed [SW-1:0] wid_r [3];
  logic signed [UW-1:0] tx_r  [3];
  logic signed [UW-1:0] ty_r  [3];
  logic [1:0]           lr_r, lc_r;

  // Walker registers
  logic [1:0]           y_r, x_r, k_r;
  logic [POS_W-1:0]     py_r, px_r, bx_r, by_r;
  logic signed [UW-1:0] vcur_r, ucur_r;
  logic [QCNT_W-1:0]    quads_r;

  // Output register
  logic                   out_valid_r;
  logic [POS_W-1:0]       o_px_r, o_py_r, o_bx_r, o_by_r;
  logic signed [UV_W-1:0] o_u_r, o_v_r;
  logic [CFG_W-1:0]       o_color_r;
  logic                   o_has_r, o_last_r;
  logic [QCNT_W-1:0]      o_quads_r;
  logic                   out_free;

  assign out_free = !out_valid_r || out_if.ready;

  // Cell qualification
  logic [2:0] row_pos, col_pos;
  logic       any_cell, row_ok, col_ok, row_end, last_v;
  logic [1:0] lr_nxt, lc_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      row_pos[i] = hgt_r[i] > 0;
      col_pos[i] = wid_r[i] > 0;
    end
    any_cell = (|row_pos) && (|col_pos);
    lr_nxt   = row_pos[2] ? 2'd2 : (row_pos[1] ? 2'd1 : 2'd0);
    lc_nxt   = col_pos[2] ? 2'd2 : (col_pos[1] ? 2'd1 : 2'd0);
    row_ok   = hgt_r[y_r] > 0;
    col_ok   = wid_r[x_r] > 0;
    row_end  = (x_r == 2'd2);
    last_v   = (y_r == lr_r) && (x_r == lc_r) && (k_r == 2'd3);
  end

  // Sequencer strobes
  logic ld_geom, ld_span, skip_row, skip_col, do_emit, do_empty;

  always_comb begin
    ld_geom  = 1'b0;
    ld_span  = 1'b0;
    skip_row = 1'b0;
    skip_col = 1'b0;
    do_emit  = 1'b0;
    do_empty = 1'b0;
    case (state_r)
      ST_MUL:  ld_geom = 1'b1;
      ST_SPAN: ld_span = 1'b1;
      ST_WALK: begin
        skip_row = !row_ok;
        skip_col = row_ok && !col_ok;
        do_emit  = row_ok && col_ok && out_free;
      end
      ST_NONE: do_empty = out_free;
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (req_pend_r) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_SPAN;
      ST_SPAN: state_nxt = any_cell ? ST_WALK : ST_NONE;
      ST_WALK: if (do_emit && last_v) state_nxt = ST_IDLE;
      ST_NONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Corner spans and row/column sizes
  logic signed [UW-1:0] ew_s, eh_s, ox_s, oy_s;

  assign ew_s = $signed(UW'(ext_r[15:0]));
  assign eh_s = $signed(UW'(ext_r[31:16]));
  assign ox_s = $signed(UW'(org_r[15:0]));
  assign oy_s = $signed(UW'(org_r[31:16]));

  always_ff @(posedge clk) begin
    if (ld_geom) begin
      hgt_r[0] <= $signed(SW'(tlsz_r[31:16]));
      hgt_r[2] <= $signed(SW'(brsz_r[31:16]));
      hgt_r[1] <= $signed(SW'(slice_r[31:16])) - $signed(SW'(tlsz_r[31:16]))
                  - $signed(SW'(brsz_r[31:16]));
      wid_r[0] <= $signed(SW'(tlsz_r[15:0]));
      wid_r[2] <= $signed(SW'(brsz_r[15:0]));
      wid_r[1] <= $signed(SW'(slice_r[15:0])) - $signed(SW'(tlsz_r[15:0]))
                  - $signed(SW'(brsz_r[15:0]));
      tx_r[0]  <= rnd_span(tlfr_r[15:0], ext_r[15:0]);
      tx_r[2]  <= rnd_span(brfr_r[15:0], ext_r[15:0]);
      ty_r[0]  <= rnd_span(tlfr_r[31:16], ext_r[31:16]);
      ty_r[2]  <= rnd_span(brfr_r[31:16], ext_r[31:16]);
    end
    if (ld_span) begin
      tx_r[1] <= ew_s - tx_r[0] - tx_r[2];
      ty_r[1] <= eh_s - ty_r[0] - ty_r[2];
      lr_r    <= lr_nxt;
      lc_r    <= lc_nxt;
    end
  end

  // Vertex datapath for the current corner
  logic signed [SW-1:0] w_cur, h_cur;
  logic [POS_W-1:0]     vx, vy, bx_nxt, by_nxt;
  logic signed [UW-1:0] u_raw, v_raw, tx_cur, ty_cur;
  logic [QCNT_W-1:0]    quads_nxt;

  always_comb begin
    w_cur     = wid_r[x_r];
    h_cur     = hgt_r[y_r];
    tx_cur    = tx_r[x_r];
    ty_cur    = ty_r[y_r];
    vx        = k_r[0] ? POS_W'(px_r + POS_W'(w_cur)) : px_r;
    vy        = k_r[1] ? POS_W'(py_r + POS_W'(h_cur)) : py_r;
    u_raw     = k_r[0] ? ucur_r + tx_cur : ucur_r;
    v_raw     = k_r[1] ? eh_s - vcur_r - ty_cur : eh_s - vcur_r;
    bx_nxt    = (vx > bx_r) ? vx : bx_r;
    by_nxt    = (vy > by_r) ? vy : by_r;
    quads_nxt = (k_r == 2'd0) ? quads_r + QCNT_W'(1) : quads_r;
  end

  // Walker: rows top to bottom, columns left to right, four corners per cell
  always_ff @(posedge clk) begin
    if (ld_span) begin
      y_r     <= 2'd0;
      x_r     <= 2'd0;
      k_r     <= 2'd0;
      py_r    <= '0;
      px_r    <= '0;
      bx_r    <= '0;
      by_r    <= '0;
      vcur_r  <= oy_s;
      ucur_r  <= ox_s;
      quads_r <= '0;
    end else if (skip_row) begin
      vcur_r <= vcur_r + ty_cur;
      y_r    <= y_r + 2'd1;
      x_r    <= 2'd0;
    end else if (skip_col || (do_emit && k_r == 2'd3)) begin
      if (row_end) begin
        py_r   <= POS_W'(py_r + POS_W'(h_cur));
        vcur_r <= vcur_r + ty_cur;
        y_r    <= y_r + 2'd1;
        x_r    <= 2'd0;
        px_r   <= '0;
        ucur_r <= ox_s;
      end else begin
        x_r    <= x_r + 2'd1;
        ucur_r <= ucur_r + tx_cur;
        if (do_emit) px_r <= POS_W'(px_r + POS_W'(w_cur));
      end
    end
    if (do_emit) begin
      k_r     <= k_r + 2'd1;
      quads_r <= quads_nxt;
      bx_r    <= bx_nxt;
      by_r    <= by_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= do_emit || do_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      o_px_r    <= vx;
      o_py_r    <= vy;
      o_u_r     <= sat_uv(u_raw);
      o_v_r     <= sat_uv(v_raw);
      o_color_r <= color_r;
      o_has_r   <= 1'b1;
      o_last_r  <= last_v;
      o_quads_r <= quads_nxt;
      o_bx_r    <= bx_nxt;
      o_by_r    <= by_nxt;
    end else if (do_empty) begin
      o_px_r    <= '0;
      o_py_r    <= '0;
      o_u_r     <= '0;
      o_v_r     <= '0;
      o_color_r <= '0;
      o_has_r   <= 1'b0;
      o_last_r  <= 1'b1;
      o_quads_r <= '0;
      o_bx_r    <= '0;
      o_by_r    <= '0;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.pos_x      = o_px_r;
  assign out_if.pos_y      = o_py_r;
  assign out_if.tex_u      = o_u_r;
  assign out_if.tex_v      = o_v_r;
  assign out_if.color      = o_color_r;
  assign out_if.has_vertex = o_has_r;
  assign out_if.is_last    = o_last_r;
  assign out_if.quad_count = o_quads_r;
  assign out_if.box_max_x  = o_bx_r;
  assign out_if.box_max_y  = o_by_r;

endmodule

`default_nettype wire
